// ===== hdl/ccar_pkg.sv =====
`timescale 1ns / 1ps

package ccar_pkg;

    localparam int ROW_MAX_DEF     = 4096;
    localparam int POS_W           = 12;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic MODE_TOTALISTIC = 1'b0;
    localparam logic MODE_RULE126    = 1'b1;

    // Which result of a transaction the back end is producing.
    typedef enum logic [2:0] {
        ST_STREAM = 3'd0,
        ST_LM2    = 3'd1,
        ST_LM1    = 3'd2,
        ST_C0     = 3'd3,
        ST_C1     = 3'd4,
        ST_SHORT  = 3'd5
    } t_step;

    typedef struct packed {
        t_step              first;
        t_step              last;
        logic [4:0]         win;
        logic [3:0]         head;
        logic               err;
        logic [POS_W-1:0]   pos_stream;
        logic [POS_W-1:0]   pos_lm2;
        logic [POS_W-1:0]   pos_lm1;
    } t_job;

    function automatic logic [2:0] popcnt5(input logic [4:0] n);
        logic [2:0] s;
        s = 3'd0;
        for (int b = 0; b < 5; b++) begin
            s = s + {2'b00, n[b]};
        end
        return s;
    endfunction

    // Bit 2 of nb is the center cell.
    function automatic logic next_cell(input logic mode, input logic [4:0] nb);
        logic [2:0] c;
        if (mode == MODE_RULE126) begin
            c = popcnt5({2'b00, nb[3:1]});
            return (c == 3'd1) || (c == 3'd2);
        end else begin
            c = popcnt5(nb);
            return (c == 3'd2) || (c == 3'd4);
        end
    endfunction

endpackage

// ===== hdl/ccar_fifo.sv =====
`timescale 1ns / 1ps

module ccar_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW:0]      r_wr;
    logic [AW:0]      r_rd;
    logic [AW:0]      n_wr;
    logic [AW:0]      n_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_data  = r_mem[r_rd[AW-1:0]];
    assign n_wr    = r_wr + (AW+1)'(1);
    assign n_rd    = r_rd + (AW+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wr <= n_wr;
            end
            if (i_pop && !o_empty) begin
                r_rd <= n_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

// ===== hdl/ccar_front.sv =====
`timescale 1ns / 1ps

module ccar_front #(
    parameter int ROW_MAX = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_cell_req,
    input  logic          i_row_end,
    output logic          o_push,
    output ccar_pkg::t_job o_job
);
    import ccar_pkg::*;

    localparam int CW  = $clog2(ROW_MAX + 1);
    localparam int SAT = ROW_MAX - 1;

    logic [3:0]    r_head;
    logic [3:0]    r_recent;
    logic [CW-1:0] r_count;
    logic [3:0]    n_head;
    logic [4:0]    win;
    logic          over;
    logic          has_stream;
    logic [31:0]   kx;

    assign win        = {r_recent, i_cell_req};
    assign over       = (r_count >= CW'(ROW_MAX));
    assign has_stream = (r_count >= CW'(4));
    assign kx         = 32'(r_count);

    always_comb begin
        n_head = r_head;
        if (!has_stream) begin
            n_head[r_count[1:0]] = i_cell_req;
        end
    end

    always_comb begin
        o_job.win        = win;
        o_job.head       = n_head;
        o_job.err        = over;
        o_job.pos_stream = over ? POS_W'(SAT) : POS_W'(kx - 32'd2);
        o_job.pos_lm2    = over ? POS_W'(SAT) : POS_W'(kx - 32'd1);
        o_job.pos_lm1    = over ? POS_W'(SAT) : POS_W'(kx);
        if (!i_row_end) begin
            o_job.first = ST_STREAM;
            o_job.last  = ST_STREAM;
        end else if (!has_stream) begin
            o_job.first = ST_SHORT;
            o_job.last  = ST_SHORT;
        end else begin
            o_job.first = ST_STREAM;
            o_job.last  = ST_C1;
        end
    end

    // A cell among the first four of a row without row end yields nothing.
    assign o_push = i_accept && (i_row_end || has_stream);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_recent <= '0;
            r_count  <= '0;
        end else if (i_accept) begin
            if (i_row_end) begin
                r_head   <= '0;
                r_recent <= '0;
                r_count  <= '0;
            end else begin
                r_head   <= n_head;
                r_recent <= win[3:0];
                if (!over) begin
                    r_count <= r_count + CW'(1);
                end
            end
        end
    end

endmodule

// ===== hdl/ccar_back.sv =====
`timescale 1ns / 1ps

module ccar_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rule_mode,
    input  ccar_pkg::t_job                 i_job,
    input  logic                           i_empty,
    output logic                           o_pop,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ccar_pkg::POS_W-1:0]     o_position,
    output logic                           o_new_cell,
    output logic                           o_final_res,
    output logic                           o_error
);
    import ccar_pkg::*;

    logic             r_valid;
    logic             r_mid;
    t_step            r_step;
    logic [POS_W-1:0] r_position;
    logic             r_new_cell;
    logic             r_final_res;
    logic             r_error;

    t_step            step;
    logic             load;
    logic             done;
    logic [4:0]       nb;
    logic [POS_W-1:0] n_position;
    logic             n_new_cell;

    assign step = r_mid ? r_step : i_job.first;
    assign load = !i_empty && (!r_valid || !i_stall);
    assign done = (step == i_job.last);
    assign o_pop = load && done;

    // Wrapped neighborhoods pull the stored head cells in after the window.
    always_comb begin
        nb         = i_job.win;
        n_position = i_job.pos_stream;
        case (step)
            ST_STREAM: begin
                nb         = i_job.win;
                n_position = i_job.pos_stream;
            end
            ST_LM2: begin
                nb         = {i_job.win[3:0], i_job.head[0]};
                n_position = i_job.pos_lm2;
            end
            ST_LM1: begin
                nb         = {i_job.win[2:0], i_job.head[0], i_job.head[1]};
                n_position = i_job.pos_lm1;
            end
            ST_C0: begin
                nb = {i_job.win[1:0], i_job.head[0], i_job.head[1], i_job.head[2]};
                n_position = POS_W'(0);
            end
            ST_C1: begin
                nb = {i_job.win[0], i_job.head[0], i_job.head[1], i_job.head[2],
                      i_job.head[3]};
                n_position = POS_W'(1);
            end
            default: begin
                nb         = '0;
                n_position = POS_W'(0);
            end
        endcase
        n_new_cell = (step == ST_SHORT) ? 1'b0 : next_cell(i_rule_mode, nb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_mid   <= 1'b0;
            r_step  <= ST_STREAM;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_mid   <= !done;
                r_step  <= t_step'(step + 3'd1);
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_position  <= n_position;
            r_new_cell  <= n_new_cell;
            r_final_res <= (step == ST_C1) || (step == ST_SHORT);
            r_error     <= i_job.err || (step == ST_SHORT);
        end
    end

    assign o_valid     = r_valid;
    assign o_position  = r_position;
    assign o_new_cell  = r_new_cell;
    assign o_final_res = r_final_res;
    assign o_error     = r_error;

endmodule

// ===== hdl/cyclic_cellular_automaton_row.sv =====
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// input     i_valid / o_stall     i_cell_req, i_row_end
// output    o_valid / i_stall     o_position, o_new_cell, o_final_res, o_error
// config    i_cfg_wr_en           i_cfg_wr_data (rule mode)
//
// A cell transaction is taken every cycle while the job queue has room; the
// back end emits one registered result per cycle unless the output stalls.
// A row end yields five results; a row of under five cells, one error result.
// Reset (synchronous, active low) empties the queue and clears the row state.
// Output stalls back up through the queue to o_stall; no transaction is lost.

module cyclic_cellular_automaton_row #(
    parameter int ROW_MAX     = ccar_pkg::ROW_MAX_DEF,
    parameter int QUEUE_DEPTH = ccar_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic                           i_cfg_wr_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cell_req,
    input  logic                           i_row_end,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ccar_pkg::POS_W-1:0]     o_position,
    output logic                           o_new_cell,
    output logic                           o_final_res,
    output logic                           o_error
);
    import ccar_pkg::*;

    logic r_rule_mode;
    logic accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_mode <= MODE_TOTALISTIC;
        end else if (i_cfg_wr_en) begin
            r_rule_mode <= i_cfg_wr_data;
        end
    end

    assign o_stall = full;
    assign accept  = i_valid && !full;

    ccar_front #(
        .ROW_MAX (ROW_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_cell_req (i_cell_req),
        .i_row_end  (i_row_end),
        .o_push     (push),
        .o_job      (job_in)
    );

    ccar_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_full  (full),
        .o_empty (empty)
    );

    ccar_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rule_mode (r_rule_mode),
        .i_job       (job_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_position  (o_position),
        .o_new_cell  (o_new_cell),
        .o_final_res (o_final_res),
        .o_error     (o_error)
    );

endmodule

// ===== dv/cyclic_cellular_automaton_row_tb.sv =====
`timescale 1ns / 1ps

module cyclic_cellular_automaton_row_tb;

    import ccar_pkg::*;

    localparam int ROW_CELLS_MAX = ROW_MAX_DEF;
    localparam int STUCK_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_LEN      = 120;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             new_cell;
        logic             final_res;
        logic             error;
    } t_cell_result;

    // Next-generation predictor for one streamed row, plus the queue of
    // results it has promised and not yet seen.
    class ccar_scoreboard;
        logic         rule_mode     = MODE_TOTALISTIC;
        logic [3:0]   head_cells    = '0;
        logic [3:0]   recent_window = '0;
        logic [12:0]  cell_count    = '0;
        t_cell_result expected_q[$];
        int           failures      = 0;

        function logic next_gen(input logic [4:0] nb);
            int live;
            if (rule_mode == MODE_RULE126) begin
                live = $countones(nb[3:1]);
                return (live == 1) || (live == 2);
            end
            live = $countones(nb);
            return (live == 2) || (live == 4);
        endfunction

        function void promise(input logic [12:0] pos, input logic val,
                              input logic fin, input logic err);
            t_cell_result r;
            r.position  = pos[POS_W-1:0];
            r.new_cell  = val;
            r.final_res = fin;
            r.error     = err;
            expected_q.push_back(r);
        endfunction

        function void note_cell(input logic cell_val, input logic last);
            logic [12:0] idx;
            logic [12:0] sat;
            logic        over;
            logic [4:0]  w5;
            logic [3:0]  h;
            idx  = cell_count;
            over = (idx >= ROW_CELLS_MAX);
            sat  = 13'(ROW_CELLS_MAX - 1);
            w5   = {recent_window, cell_val};
            if (idx < 4)
                head_cells[idx[1:0]] = cell_val;
            if (idx >= 4)
                promise(over ? sat : idx - 13'd2, next_gen(w5), 1'b0, over);
            if (!last) begin
                recent_window = w5[3:0];
                if (cell_count < ROW_CELLS_MAX)
                    cell_count++;
                return;
            end
            if (idx < 4) begin
                // A row too short for a full neighborhood yields one error result.
                promise('0, 1'b0, 1'b1, 1'b1);
            end else begin
                // The tail wraps around onto the stored head of the row.
                h = head_cells;
                promise(over ? sat : idx - 13'd1, next_gen({w5[3:0], h[0]}), 1'b0, over);
                promise(over ? sat : idx, next_gen({w5[2:0], h[0], h[1]}), 1'b0, over);
                promise(13'd0, next_gen({w5[1:0], h[0], h[1], h[2]}), 1'b0, over);
                promise(13'd1, next_gen({w5[0], h[0], h[1], h[2], h[3]}), 1'b1, over);
            end
            head_cells    = '0;
            recent_window = '0;
            cell_count    = '0;
        endfunction

        function void check_result(input t_cell_result got);
            t_cell_result want;
            if (expected_q.size() == 0) begin
                failures++;
                $display("%0t: unexpected result pos=%0d cell=%0b fin=%0b err=%0b",
                         $time, got.position, got.new_cell, got.final_res, got.error);
                return;
            end
            want = expected_q.pop_front();
            if (want !== got) begin
                failures++;
                $display("%0t: mismatch expected pos=%0d cell=%0b fin=%0b err=%0b, %s",
                         $time, want.position, want.new_cell, want.final_res,
                         want.error,
                         $sformatf("actual pos=%0d cell=%0b fin=%0b err=%0b",
                                   got.position, got.new_cell, got.final_res,
                                   got.error));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void close_out();
            if (expected_q.size() != 0) begin
                failures += expected_q.size();
                $display("%0t: %0d expected results never arrived", $time,
                         expected_q.size());
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic             i_cfg_wr_data;
    logic             i_valid;
    logic             o_stall;
    logic             i_cell_req;
    logic             i_row_end;
    logic             o_valid;
    logic             i_stall;
    logic [POS_W-1:0] o_position;
    logic             o_new_cell;
    logic             o_final_res;
    logic             o_error;

    ccar_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_reqs     = 0;
    int holds_done    = 0;
    int hold_cnt      = 0;
    int stuck_cycles  = 0;

    cyclic_cellular_automaton_row dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cell_req    (i_cell_req),
        .i_row_end     (i_row_end),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_position    (o_position),
        .o_new_cell    (o_new_cell),
        .o_final_res   (o_final_res),
        .o_error       (o_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Downstream side: random back-pressure, or a long hold-off when asked.
    always @(posedge i_clk) begin
        if (holds_done != hold_reqs) begin
            holds_done <= hold_reqs;
            hold_cnt   <= HOLD_LEN;
            i_stall    <= 1'b1;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_stall  <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result({o_position, o_new_cell, o_final_res, o_error});
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STUCK_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    task automatic send_cell(input logic cell_val, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_cell_req <= cell_val;
        i_row_end  <= last;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_cell(cell_val, last);
    endtask

    // density is the chance, in percent, that a cell is alive.
    task automatic send_row(input int len, input int density);
        for (int i = 0; i < len; i++)
            send_cell($urandom_range(99) < density, i == len - 1);
    endtask

    task automatic random_rows(input int n_items);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 15)
                len = $urandom_range(1, 4);
            else if (pick < 85)
                len = $urandom_range(5, 16);
            else
                len = $urandom_range(17, 40);
            send_row(len, $urandom_range(0, 100));
            sent += len;
        end
    endtask

    // Must be called in the same time step as the last acceptance so that
    // the final transaction is not taken twice.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic mode);
        wait_drained();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.rule_mode = mode;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 1'b0;
        i_valid       = 1'b0;
        i_cell_req    = 1'b0;
        i_row_end     = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under the reset mode: single cell, short row of
        // zeros, a minimal row of all ones, and a couple of mixed rows.
        send_row(1, 100);
        send_row(4, 0);
        send_row(5, 100);
        send_row(6, 50);
        send_row(7, 50);

        write_mode(MODE_RULE126);
        send_row(5, 100);
        send_row(5, 0);
        send_row(2, 50);

        write_mode(MODE_TOTALISTIC);
        send_idle_pct = 31;
        recv_idle_pct = 64;
        hold_reqs++;
        random_rows(35);

        write_mode(MODE_RULE126);
        send_idle_pct = 64;
        recv_idle_pct = 31;
        random_rows(35);

        write_mode(MODE_TOTALISTIC);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_reqs++;
        random_rows(35);

        wait_drained();
        sb.close_out();
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
